// File: hw/rtl/euler_to_rotation_matrix_unit_assert.svh
// Assertion macros of the rotation matrix unit, used by its output stage
`ifndef EULER_TO_ROTATION_MATRIX_UNIT_ASSERT_SVH
`define EULER_TO_ROTATION_MATRIX_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define ETR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ETR_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ETR_ASSERT(lbl, prop, msg)
`define ETR_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// File: hw/rtl/etr_pkg.sv
// Shared types, constants and fixed-point helpers of the rotation matrix unit
package etr_pkg;

    localparam int          IN_W        = 48;
    localparam int          NSTEP       = 6;
    localparam int          NELEM       = 9;
    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    // Taylor divisors and floor(2^32 / k) for the sine series
    localparam logic [7:0]  KDIV [NSTEP]   = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [31:0] KRECIP [NSTEP] = '{32'd27531841, 32'd39045157, 32'd59652323,
                                               32'd102261126, 32'd214748364, 32'd715827882};

    // matrix element positions, lowest first in the result word
    localparam int R0X = 0;
    localparam int R0Y = 1;
    localparam int R0Z = 2;
    localparam int R1X = 3;
    localparam int R1Y = 4;
    localparam int R1Z = 5;
    localparam int R2X = 6;
    localparam int R2Y = 7;
    localparam int R2Z = 8;

    typedef struct packed {
        logic        neg;
        logic [30:0] mag;
    } sm_t;

    typedef struct packed {
        logic        neg;
        logic [61:0] mag;
    } wide_t;

    typedef logic signed [32:0] elem_t;
    typedef elem_t [NELEM-1:0] mat_t;

    function automatic wide_t sm_mul(sm_t a, sm_t b);
        wide_t w;
        w.neg = a.neg ^ b.neg;
        w.mag = 62'(a.mag) * 62'(b.mag);
        return w;
    endfunction

    // Q60 back to Q30, half away from zero
    function automatic sm_t sm_round(wide_t w);
        sm_t s;
        s.neg = w.neg;
        s.mag = 31'((w.mag + (62'(1) << 29)) >> 30);
        return s;
    endfunction

    function automatic elem_t sm_to_elem(sm_t a);
        elem_t e;
        e = elem_t'({2'b00, a.mag});
        return a.neg ? -e : e;
    endfunction

endpackage

// File: hw/rtl/euler_to_rotation_matrix_unit.sv
// Euler angles (yaw, pitch, roll) to 3x3 rotation matrix, top level
//
// Takes yaw, pitch and roll as binary angles (2^ANGLE_BITS codes per turn) and returns
// the forward, left and up rows of the rotation matrix as signed Q1.(OUT_BITS-1), +1.0
// saturating to the largest code. One request is accepted per clock and one result
// leaves per clock while neither end stalls. From input handshake to m_tvalid, a
// request passes the six-step sine series (four stages a step) in each of the six sine
// lanes, the two rounds of products in the matrix stage, and the output scaling and
// register. A two-entry output register and skid buffer keep s_tready free of any path
// from m_tready; s_tready drops only once both entries hold results.
module euler_to_rotation_matrix_unit
    import etr_pkg::*;
#(
    parameter int ANGLE_BITS = 16,
    parameter int OUT_BITS   = 16
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // yaw_angle, pitch_angle, roll_angle (16 bits each)
    input  logic [IN_W-1:0]                        s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // row0_x, row0_y, row0_z, row1_x, row1_y, row1_z, row2_x, row2_y, row2_z
    output logic [((NELEM*OUT_BITS+7)/8)*8-1:0]    m_tdata
);
    localparam int OUT_W = ((NELEM * OUT_BITS + 7) / 8) * 8;
    localparam int NLANE = 6;

    logic                  en;
    logic [ANGLE_BITS-1:0] lane_angle [NLANE];
    sm_t                   lane_sine  [NLANE];
    logic [NLANE-1:0]      lane_v;
    logic                  mat_v;
    mat_t                  mat;

    assign s_tready = en;

    // lanes: sin yaw, cos yaw, sin pitch, cos pitch, sin roll, cos roll
    for (genvar i = 0; i < NLANE; i++)
    begin : g_lane
        assign lane_angle[i] = ANGLE_BITS'(s_tdata[16*(i/2) +: 16])
                             + (ANGLE_BITS'(i % 2) << (ANGLE_BITS - 2));

        etr_sine #(
            .ANGLE_BITS (ANGLE_BITS)
        ) u_sine (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (s_tvalid),
            .angle     (lane_angle[i]),
            .out_valid (lane_v[i]),
            .sine      (lane_sine[i])
        );
    end

    etr_matrix u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (&lane_v),
        .sy        (lane_sine[0]),
        .cy        (lane_sine[1]),
        .sp        (lane_sine[2]),
        .cp        (lane_sine[3]),
        .sr        (lane_sine[4]),
        .cr        (lane_sine[5]),
        .out_valid (mat_v),
        .mat       (mat)
    );

    etr_out #(
        .OUT_BITS (OUT_BITS),
        .OUT_W    (OUT_W)
    ) u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (mat_v),
        .mat      (mat),
        .ready    (en),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: hw/rtl/etr_sine.sv
// Pipelined sine of one binary angle, sign-magnitude Q30 result
module etr_sine
    import etr_pkg::*;
#(
    parameter int ANGLE_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [ANGLE_BITS-1:0] angle,
    output logic                  out_valid,
    output sm_t                   sine
);
    localparam int              RB    = ANGLE_BITS - 2;
    localparam int              MW    = RB + 32;
    localparam int              LAT   = 7 + 4 * NSTEP;
    localparam logic [RB:0]     QSIZE = (RB+1)'(1) << RB;
    localparam logic [MW-1:0]   X_RND = MW'(1) << (RB - 1);

    logic [LAT-1:0] v_reg;
    logic [1:0]     quad;
    logic [RB:0]    r_ext;

    logic [RB:0]    s1_rr_reg;
    logic           s1_neg_reg;
    logic [MW-1:0]  s2_m_reg;
    logic           s2_neg_reg;
    logic [30:0]    s3_x_reg;
    logic           s3_neg_reg;
    logic [61:0]    s4_xx_reg;
    logic [30:0]    s4_x_reg;
    logic           s4_neg_reg;

    logic [30:0]    it_t_reg   [0:NSTEP];
    logic [30:0]    it_x_reg   [0:NSTEP];
    logic [31:0]    it_x2_reg  [0:NSTEP];
    logic           it_neg_reg [0:NSTEP];

    wide_t          f1_s_reg;
    sm_t            f2_sine_reg;

    assign quad  = angle[ANGLE_BITS-1 -: 2];
    assign r_ext = {1'b0, angle[RB-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // fold into the first quadrant
            s1_rr_reg     <= quad[0] ? QSIZE - r_ext : r_ext;
            s1_neg_reg    <= quad[1];
            s2_m_reg      <= MW'(s1_rr_reg) * MW'(HALF_PI_Q30);
            s2_neg_reg    <= s1_neg_reg;
            s3_x_reg      <= 31'((s2_m_reg + X_RND) >> RB);
            s3_neg_reg    <= s2_neg_reg;
            s4_xx_reg     <= 62'(s3_x_reg) * 62'(s3_x_reg);
            s4_x_reg      <= s3_x_reg;
            s4_neg_reg    <= s3_neg_reg;
            it_t_reg[0]   <= ONE_Q30;
            it_x_reg[0]   <= s4_x_reg;
            it_x2_reg[0]  <= 32'((s4_xx_reg + (62'(1) << 29)) >> 30);
            it_neg_reg[0] <= s4_neg_reg;
            f1_s_reg      <= '{neg: it_neg_reg[NSTEP],
                               mag: 62'(it_x_reg[NSTEP]) * 62'(it_t_reg[NSTEP])};
            f2_sine_reg   <= sm_round(f1_s_reg);
        end
    end

    // Horner steps: t = 1 - x2*t/k, each over four stages
    for (genvar i = 0; i < NSTEP; i++)
    begin : g_step
        logic [62:0] a_p_reg;
        logic [30:0] a_x_reg, b_x_reg, c_x_reg;
        logic [31:0] a_x2_reg, b_x2_reg, c_x2_reg;
        logic        a_neg_reg, b_neg_reg, c_neg_reg;
        logic [31:0] b_u_reg, c_u_reg;
        logic [63:0] c_prod_reg;
        logic [31:0] q0;
        logic [39:0] rem;
        logic [32:0] d;

        always_comb
        begin
            q0  = c_prod_reg[63:32];
            rem = 40'(c_u_reg) - 40'(q0) * 40'(KDIV[i]);
            d   = 33'(q0) + 33'(rem >= 40'(KDIV[i]));
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a_p_reg           <= 63'(it_x2_reg[i]) * 63'(it_t_reg[i]);
                a_x_reg           <= it_x_reg[i];
                a_x2_reg          <= it_x2_reg[i];
                a_neg_reg         <= it_neg_reg[i];
                b_u_reg           <= 32'((a_p_reg + (63'(KDIV[i]) << 29)) >> 30);
                b_x_reg           <= a_x_reg;
                b_x2_reg          <= a_x2_reg;
                b_neg_reg         <= a_neg_reg;
                c_prod_reg        <= 64'(b_u_reg) * 64'(KRECIP[i]);
                c_u_reg           <= b_u_reg;
                c_x_reg           <= b_x_reg;
                c_x2_reg          <= b_x2_reg;
                c_neg_reg         <= b_neg_reg;
                it_t_reg[i+1]     <= (d >= 33'(ONE_Q30)) ? '0 : 31'(33'(ONE_Q30) - d);
                it_x_reg[i+1]     <= c_x_reg;
                it_x2_reg[i+1]    <= c_x2_reg;
                it_neg_reg[i+1]   <= c_neg_reg;
            end
        end
    end

    assign out_valid = v_reg[LAT-1];
    assign sine      = f2_sine_reg;

endmodule

// File: hw/rtl/etr_matrix.sv
// Products and sums that form the nine matrix elements in signed Q30
module etr_matrix
    import etr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  sm_t  sy,
    input  sm_t  cy,
    input  sm_t  sp,
    input  sm_t  cp,
    input  sm_t  sr,
    input  sm_t  cr,
    output logic out_valid,
    output mat_t mat
);
    localparam int LAT = 5;

    logic [LAT-1:0] v_reg;

    wide_t m1_srsp_reg, m1_crsp_reg, m1_cpcy_reg, m1_cpsy_reg, m1_crsy_reg;
    wide_t m1_crcy_reg, m1_srcp_reg, m1_srsy_reg, m1_srcy_reg, m1_crcp_reg;
    sm_t   m1_sy_reg, m1_cy_reg, m1_sp_reg;

    sm_t   m2_srsp_reg, m2_crsp_reg, m2_cpcy_reg, m2_cpsy_reg, m2_crsy_reg;
    sm_t   m2_crcy_reg, m2_srcp_reg, m2_srsy_reg, m2_srcy_reg, m2_crcp_reg;
    sm_t   m2_sy_reg, m2_cy_reg, m2_sp_reg;

    wide_t m3_srspcy_reg, m3_srspsy_reg, m3_crspcy_reg, m3_crspsy_reg;
    sm_t   m3_cpcy_reg, m3_cpsy_reg, m3_crsy_reg, m3_crcy_reg;
    sm_t   m3_srcp_reg, m3_srsy_reg, m3_srcy_reg, m3_crcp_reg, m3_sp_reg;

    sm_t   m4_srspcy_reg, m4_srspsy_reg, m4_crspcy_reg, m4_crspsy_reg;
    sm_t   m4_cpcy_reg, m4_cpsy_reg, m4_crsy_reg, m4_crcy_reg;
    sm_t   m4_srcp_reg, m4_srsy_reg, m4_srcy_reg, m4_crcp_reg, m4_sp_reg;

    mat_t  mat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_srsp_reg <= sm_mul(sr, sp);
            m1_crsp_reg <= sm_mul(cr, sp);
            m1_cpcy_reg <= sm_mul(cp, cy);
            m1_cpsy_reg <= sm_mul(cp, sy);
            m1_crsy_reg <= sm_mul(cr, sy);
            m1_crcy_reg <= sm_mul(cr, cy);
            m1_srcp_reg <= sm_mul(sr, cp);
            m1_srsy_reg <= sm_mul(sr, sy);
            m1_srcy_reg <= sm_mul(sr, cy);
            m1_crcp_reg <= sm_mul(cr, cp);
            m1_sy_reg   <= sy;
            m1_cy_reg   <= cy;
            m1_sp_reg   <= sp;

            m2_srsp_reg <= sm_round(m1_srsp_reg);
            m2_crsp_reg <= sm_round(m1_crsp_reg);
            m2_cpcy_reg <= sm_round(m1_cpcy_reg);
            m2_cpsy_reg <= sm_round(m1_cpsy_reg);
            m2_crsy_reg <= sm_round(m1_crsy_reg);
            m2_crcy_reg <= sm_round(m1_crcy_reg);
            m2_srcp_reg <= sm_round(m1_srcp_reg);
            m2_srsy_reg <= sm_round(m1_srsy_reg);
            m2_srcy_reg <= sm_round(m1_srcy_reg);
            m2_crcp_reg <= sm_round(m1_crcp_reg);
            m2_sy_reg   <= m1_sy_reg;
            m2_cy_reg   <= m1_cy_reg;
            m2_sp_reg   <= m1_sp_reg;

            // triple products, left to right
            m3_srspcy_reg <= sm_mul(m2_srsp_reg, m2_cy_reg);
            m3_srspsy_reg <= sm_mul(m2_srsp_reg, m2_sy_reg);
            m3_crspcy_reg <= sm_mul(m2_crsp_reg, m2_cy_reg);
            m3_crspsy_reg <= sm_mul(m2_crsp_reg, m2_sy_reg);
            m3_cpcy_reg   <= m2_cpcy_reg;
            m3_cpsy_reg   <= m2_cpsy_reg;
            m3_crsy_reg   <= m2_crsy_reg;
            m3_crcy_reg   <= m2_crcy_reg;
            m3_srcp_reg   <= m2_srcp_reg;
            m3_srsy_reg   <= m2_srsy_reg;
            m3_srcy_reg   <= m2_srcy_reg;
            m3_crcp_reg   <= m2_crcp_reg;
            m3_sp_reg     <= m2_sp_reg;

            m4_srspcy_reg <= sm_round(m3_srspcy_reg);
            m4_srspsy_reg <= sm_round(m3_srspsy_reg);
            m4_crspcy_reg <= sm_round(m3_crspcy_reg);
            m4_crspsy_reg <= sm_round(m3_crspsy_reg);
            m4_cpcy_reg   <= m3_cpcy_reg;
            m4_cpsy_reg   <= m3_cpsy_reg;
            m4_crsy_reg   <= m3_crsy_reg;
            m4_crcy_reg   <= m3_crcy_reg;
            m4_srcp_reg   <= m3_srcp_reg;
            m4_srsy_reg   <= m3_srsy_reg;
            m4_srcy_reg   <= m3_srcy_reg;
            m4_crcp_reg   <= m3_crcp_reg;
            m4_sp_reg     <= m3_sp_reg;

            mat_reg[R0X] <= sm_to_elem(m4_cpcy_reg);
            mat_reg[R0Y] <= sm_to_elem(m4_cpsy_reg);
            mat_reg[R0Z] <= -sm_to_elem(m4_sp_reg);
            mat_reg[R1X] <= sm_to_elem(m4_srspcy_reg) - sm_to_elem(m4_crsy_reg);
            mat_reg[R1Y] <= sm_to_elem(m4_srspsy_reg) + sm_to_elem(m4_crcy_reg);
            mat_reg[R1Z] <= sm_to_elem(m4_srcp_reg);
            mat_reg[R2X] <= sm_to_elem(m4_crspcy_reg) + sm_to_elem(m4_srsy_reg);
            mat_reg[R2Y] <= sm_to_elem(m4_crspsy_reg) - sm_to_elem(m4_srcy_reg);
            mat_reg[R2Z] <= sm_to_elem(m4_crcp_reg);
        end
    end

    assign out_valid = v_reg[LAT-1];
    assign mat       = mat_reg;

endmodule

// File: hw/rtl/etr_out.sv
// Output scaling, saturation, output register and skid buffer
`include "euler_to_rotation_matrix_unit_assert.svh"
module etr_out
    import etr_pkg::*;
#(
    parameter int OUT_BITS = 16,
    parameter int OUT_W    = 144
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  mat_t             mat,
    output logic             ready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata
);
    localparam int          SH   = 31 - OUT_BITS;
    localparam int          SHR  = (SH > 0) ? SH : 1;
    localparam int          SHL  = (SH > 0) ? 0 : -SH;
    localparam logic [33:0] MAXP = 34'((64'(1) << (OUT_BITS - 1)) - 64'(1));

    logic               o1_v_reg;
    logic               o1_neg_reg [NELEM];
    logic [31:0]        o1_mag_reg [NELEM];

    logic [OUT_W-1:0]   word;
    logic [NELEM*OUT_BITS-1:0] packed_word;

    logic               out_v_reg, out_v_next;
    logic [OUT_W-1:0]   out_d_reg, out_d_next;
    logic               skid_v_reg, skid_v_next;
    logic [OUT_W-1:0]   skid_d_reg, skid_d_next;

    function automatic logic [OUT_BITS-1:0] conv(logic neg, logic [31:0] mag);
        logic [33:0] m;
        if (SH > 0)
        begin
            m = (34'(mag) + (34'(1) << (SHR - 1))) >> SHR;
        end
        else
        begin
            m = 34'(mag) << SHL;
        end
        if (neg)
        begin
            if (m > MAXP + 34'(1))
            begin
                m = MAXP + 34'(1);
            end
            return OUT_BITS'(34'(0) - m);
        end
        if (m > MAXP)
        begin
            m = MAXP;
        end
        return OUT_BITS'(m);
    endfunction

    assign ready = !skid_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o1_v_reg <= 1'b0;
        end
        else if (ready)
        begin
            o1_v_reg <= in_valid;
        end
    end

    for (genvar k = 0; k < NELEM; k++)
    begin : g_elem
        always_ff @(posedge clk)
        begin
            if (ready)
            begin
                o1_neg_reg[k] <= mat[k][32];
                o1_mag_reg[k] <= 32'(mat[k][32] ? -mat[k] : mat[k]);
            end
        end
        assign packed_word[k*OUT_BITS +: OUT_BITS] = conv(o1_neg_reg[k], o1_mag_reg[k]);
    end

    assign word = OUT_W'(packed_word);

    always_comb
    begin
        out_v_next  = out_v_reg;
        out_d_next  = out_d_reg;
        skid_v_next = skid_v_reg;
        skid_d_next = skid_d_reg;
        if (skid_v_reg)
        begin
            if (m_tready)
            begin
                out_d_next  = skid_d_reg;
                skid_v_next = 1'b0;
            end
        end
        else if (!out_v_reg || m_tready)
        begin
            out_v_next = o1_v_reg;
            if (o1_v_reg)
            begin
                out_d_next = word;
            end
        end
        else if (o1_v_reg)
        begin
            skid_v_next = 1'b1;
            skid_d_next = word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_d_reg  <= out_d_next;
        skid_d_reg <= skid_d_next;
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_d_reg;

    `ETR_ASSERT(a_skid_behind_out, skid_v_reg |-> out_v_reg, "skid full with output empty")
    `ETR_ASSERT_NEXT(a_skid_catch, ready && o1_v_reg && out_v_reg && !m_tready, skid_v_reg, "request lost on stall")
    `ETR_ASSERT_NEXT(a_skid_drain, skid_v_reg && m_tready, out_v_reg && !skid_v_reg, "skid not drained")

endmodule

// File: tb/euler_to_rotation_matrix_unit_test.sv
// Testbench for the Euler angle to rotation matrix unit: self-predicting stream checks
module euler_to_rotation_matrix_unit_test;
    import etr_pkg::*;

    localparam int ANG_W = 16;
    localparam int OUT_W = 16;
    localparam int OD_W  = ((NELEM*OUT_W+7)/8)*8;

    typedef logic [NELEM*OUT_W-1:0] matrix_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [OD_W-1:0]   m_tdata;

    matrix_t           expected_matrices[$];
    int                fail_count;
    int                send_idle_pct;
    int                recv_stall_pct;
    int                hold_off_cycles;

    euler_to_rotation_matrix_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    initial
    begin
        #100000000;
        $display("Regression FAIL");
        $finish;
    end

    // quarter-wave sine, unsigned Q30 in and out
    function automatic longint unsigned quarter_sin(longint unsigned x);
        longint unsigned x2;
        longint unsigned t;
        longint unsigned den;
        longint unsigned d;
        longint unsigned divs[6];
        divs = '{156, 110, 72, 42, 20, 6};
        x2 = (x * x + (64'd1 << 29)) >> 30;
        t  = 64'd1 << 30;
        for (int i = 0; i < 6; i++)
        begin
            den = divs[i] << 30;
            d   = (x2 * t + (den >> 1)) / den;
            t   = (d >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - d;
        end
        return (x * t + (64'd1 << 29)) >> 30;
    endfunction

    function automatic longint angle_sin(longint unsigned a);
        longint unsigned qs;
        longint unsigned q;
        longint unsigned r;
        longint unsigned x;
        longint unsigned s;
        qs = 64'd1 << (ANG_W - 2);
        a  = a & ((64'd1 << ANG_W) - 1);
        q  = (a >> (ANG_W - 2)) & 3;
        r  = a & (qs - 1);
        if (q[0])
            r = qs - r;
        x = (r * 64'd1686629713 + (qs >> 1)) >> (ANG_W - 2);
        s = quarter_sin(x);
        return q[1] ? -longint'(s) : longint'(s);
    endfunction

    function automatic longint q30_mul(longint a, longint b);
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned m;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        m  = (ma * mb + (64'd1 << 29)) >> 30;
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [OUT_W-1:0] q30_to_out(longint v);
        longint unsigned m;
        longint unsigned maxpos;
        int sh;
        maxpos = (64'd1 << (OUT_W - 1)) - 1;
        sh = 31 - OUT_W;
        m  = v < 0 ? -v : v;
        m  = (m + (64'd1 << (sh - 1))) >> sh;
        if (v < 0)
        begin
            if (m > maxpos + 1)
                m = maxpos + 1;
            return OUT_W'(-m);
        end
        if (m > maxpos)
            m = maxpos;
        return OUT_W'(m);
    endfunction

    function automatic matrix_t rotation_matrix(logic [15:0] yaw, logic [15:0] pitch,
                                                logic [15:0] roll);
        longint unsigned qt;
        longint sy, cy, sp, cp, sr, cr, srsp, crsp;
        longint e[NELEM];
        matrix_t mat;
        qt   = 64'd1 << (ANG_W - 2);
        sy   = angle_sin(yaw);
        cy   = angle_sin(yaw + qt);
        sp   = angle_sin(pitch);
        cp   = angle_sin(pitch + qt);
        sr   = angle_sin(roll);
        cr   = angle_sin(roll + qt);
        srsp = q30_mul(sr, sp);
        crsp = q30_mul(cr, sp);
        e[R0X] = q30_mul(cp, cy);
        e[R0Y] = q30_mul(cp, sy);
        e[R0Z] = -sp;
        e[R1X] = q30_mul(srsp, cy) - q30_mul(cr, sy);
        e[R1Y] = q30_mul(srsp, sy) + q30_mul(cr, cy);
        e[R1Z] = q30_mul(sr, cp);
        e[R2X] = q30_mul(crsp, cy) + q30_mul(sr, sy);
        e[R2Y] = q30_mul(crsp, sy) - q30_mul(sr, cy);
        e[R2Z] = q30_mul(cr, cp);
        for (int i = 0; i < NELEM; i++)
            mat[i*OUT_W +: OUT_W] = q30_to_out(e[i]);
        return mat;
    endfunction

    // s_tvalid stays high on return; the next request or the idle loop takes it on
    task automatic send_request(logic [15:0] yaw, logic [15:0] pitch, logic [15:0] roll);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {roll, pitch, yaw};
        expected_matrices.push_back(rotation_matrix(yaw, pitch, roll));
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // receiver side: random stalls plus an optional long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        matrix_t exp_m;
        string names[NELEM];
        names = '{"row0_x", "row0_y", "row0_z", "row1_x", "row1_y", "row1_z",
                  "row2_x", "row2_y", "row2_z"};
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_matrices.size() == 0)
            begin
                $error("unexpected result %h", m_tdata);
                fail_count++;
            end
            else
            begin
                exp_m = expected_matrices.pop_front();
                for (int i = 0; i < NELEM; i++)
                    if (m_tdata[i*OUT_W +: OUT_W] !== exp_m[i*OUT_W +: OUT_W])
                    begin
                        $error("%s: expected %0d, got %0d", names[i],
                               $signed(exp_m[i*OUT_W +: OUT_W]),
                               $signed(m_tdata[i*OUT_W +: OUT_W]));
                        fail_count++;
                    end
            end
        end
    end

    task automatic test_directed();
        logic [15:0] corners[8];
        corners = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h0001,
                    16'h2000, 16'h3FFF};
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 8; i++)
            send_request(corners[i], corners[(i + 3) % 8], corners[(i + 5) % 8]);
        send_request(16'h0000, 16'h0000, 16'h0000);
        send_request(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(16'h4000, 16'h4000, 16'h4000);
        send_request(16'h8000, 16'hC000, 16'h0000);
        send_request(16'hAAAA, 16'h5555, 16'hAAAA);
        send_request(16'h5555, 16'hAAAA, 16'h5555);
    endtask

    task automatic test_random(int count, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
            send_request(16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 120;
        for (int i = 0; i < 80; i++)
            send_request(16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    initial
    begin
        int guard;
        fail_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(180, 0, 0);
        test_random(180, 71, 0);
        test_random(180, 0, 71);
        test_random(180, 15, 15);
        test_backpressure();
        s_tvalid <= 1'b0;
        guard = 0;
        while (expected_matrices.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (60) @(posedge clk);
        if (fail_count == 0 && expected_matrices.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/etr_pkg.sv
hw/rtl/etr_sine.sv
hw/rtl/etr_matrix.sv
hw/rtl/etr_out.sv
hw/rtl/euler_to_rotation_matrix_unit.sv
tb/euler_to_rotation_matrix_unit_test.sv
